// ===== rtl/rgbc_pkg.sv =====
package rgbc_pkg;

    localparam int unsigned CntW   = 16;
    localparam int unsigned RatioW = 16;
    localparam int unsigned RefW   = 48;
    localparam int unsigned NumRef = 6;
    localparam int unsigned CodeW  = 3;
    localparam int unsigned QuotW  = 30;  // count*10000 < 2^30
    localparam int unsigned DistW  = 41;  // 100 * 3 * 65535^2 < 2^41

    typedef logic [CodeW-1:0] t_code;
    localparam t_code CodeRed     = 3'd0;
    localparam t_code CodeGreen   = 3'd1;
    localparam t_code CodeBlue    = 3'd2;
    localparam t_code CodeYellow  = 3'd3;
    localparam t_code CodeWhite   = 3'd4;
    localparam t_code CodeBlack   = 3'd5;
    localparam t_code CodeUnknown = 3'd6;

    typedef enum logic [2:0] {
        RegEnable = 3'd0,
        RegMask   = 3'd1,
        RegRed    = 3'd2,
        RegGreen  = 3'd3,
        RegBlue   = 3'd4,
        RegYellow = 3'd5,
        RegWhite  = 3'd6,
        RegBlack  = 3'd7
    } t_reg_idx;

    localparam logic [RatioW-1:0] RatioMax  = 16'hFFFF;
    localparam logic [13:0]       RatioScale = 14'd10000;
    localparam logic [DistW-1:0]  DistLimit = 41'd350000000;

    typedef logic [RatioW-1:0] t_rgb [3];

    // Flags produced by the rule stage for the decision stage
    typedef struct packed {
        logic kill;    // disabled or dim
        logic dark;    // clear < 180
        logic bright;  // clear > 450
        logic white;
        logic red;
        logic yellow;
        logic green;
        logic blue;
    } t_rule_flags;

    function automatic logic [RatioW-1:0] ref_ch(input logic [RefW-1:0] r, input int ch);
        ref_ch = r[47-16*ch -: 16];
    endfunction

    function automatic logic [RatioW-1:0] absd(input logic [RatioW-1:0] a,
                                              input logic [RatioW-1:0] b);
        absd = (a >= b) ? a - b : b - a;
    endfunction

endpackage

// ===== rtl/rgbc_divider.sv =====
// Pipelined restoring divider: quotient of (count*10000)/clear, one radix-2
// step per stage over QuotW stages, clipped to 16 bits.
module rgbc_divider (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rgbc_pkg::CntW-1:0]  i_num,
    input  logic [rgbc_pkg::CntW-1:0]  i_den,
    output logic [rgbc_pkg::RatioW-1:0] o_quot
);
    import rgbc_pkg::*;

    logic [QuotW-1:0] r_num [QuotW+1];
    logic [CntW:0]    r_rem [QuotW+1];
    logic [CntW-1:0]  r_den [QuotW+1];

    // Scale the count on entry
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= QuotW'(i_num) * QuotW'(RatioScale);
            r_rem[0] <= '0;
            r_den[0] <= i_den;
        end
    end

    // One quotient bit per stage; quotient bits shift into r_num
    for (genvar s = 0; s < QuotW; s++) begin : g_step
        logic [CntW+1:0] w_sh;
        logic [CntW+1:0] w_sub;
        always_comb begin
            w_sh  = {r_rem[s], r_num[s][QuotW-1]};
            w_sub = w_sh - {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1] <= r_den[s];
                if (!w_sub[CntW+1]) begin
                    r_rem[s+1] <= w_sub[CntW:0];
                    r_num[s+1] <= {r_num[s][QuotW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= w_sh[CntW:0];
                    r_num[s+1] <= {r_num[s][QuotW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quot = (|r_num[QuotW][QuotW-1:RatioW]) ? RatioMax : r_num[QuotW][RatioW-1:0];
endmodule

// ===== rtl/rgbc_rules.sv =====
// Rule tests and per-reference squared distances, registered in two stages.
module rgbc_rules (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_kill,
    input  logic [rgbc_pkg::CntW-1:0]     i_clear,
    input  logic [rgbc_pkg::RatioW-1:0]   i_cr,
    input  logic [rgbc_pkg::RatioW-1:0]   i_cg,
    input  logic [rgbc_pkg::RatioW-1:0]   i_cb,
    input  logic [rgbc_pkg::NumRef-1:0]   i_mask,
    input  logic [rgbc_pkg::RefW-1:0]     i_refs [rgbc_pkg::NumRef],
    output rgbc_pkg::t_rule_flags         o_flags,
    output logic [rgbc_pkg::DistW-1:0]    o_dist [rgbc_pkg::NumRef]
);
    import rgbc_pkg::*;

    logic [RatioW-1:0] w_c [3];
    assign w_c[0] = i_cr;
    assign w_c[1] = i_cg;
    assign w_c[2] = i_cb;

    // Dominant-channel rule for the colour at index p
    function automatic logic dom(input logic [RefW-1:0] r, input int p,
                                 input logic [RatioW-1:0] c0, input logic [RatioW-1:0] c1,
                                 input logic [RatioW-1:0] c2);
        logic signed [24:0] cp, rp, cq, rq;
        logic ok;
        logic [RatioW-1:0] cv [3];
        cv[0] = c0; cv[1] = c1; cv[2] = c2;
        cp = 25'(cv[p]);
        rp = 25'(ref_ch(r, p));
        ok = (cp * 100) >= (rp * 90);
        for (int q = 0; q < 3; q++) begin
            cq = 25'(cv[q]);
            rq = 25'(ref_ch(r, q));
            if (q != p && (5 * cp < 5 * cq + 4 * (rp - rq))) ok = 1'b0;
        end
        return ok;
    endfunction

    logic w_white, w_red, w_green, w_blue, w_yel;
    logic [RatioW-1:0] w_yr, w_yg, w_yb, w_wr, w_wg, w_wb;
    logic [16:0] w_sum, w_ysum;
    always_comb begin
        w_wr = ref_ch(i_refs[CodeWhite], 0);
        w_wg = ref_ch(i_refs[CodeWhite], 1);
        w_wb = ref_ch(i_refs[CodeWhite], 2);
        w_white = i_mask[CodeWhite] && (i_clear > 16'd1800) && (absd(i_cr, w_wr) < 16'd700)
                  && (absd(i_cg, w_wg) < 16'd700) && (absd(i_cb, w_wb) < 16'd700);
        w_red   = i_mask[CodeRed]   && (i_clear > 16'd250) && dom(i_refs[CodeRed], 0, i_cr, i_cg, i_cb);
        w_green = i_mask[CodeGreen] && (i_clear > 16'd250) && dom(i_refs[CodeGreen], 1, i_cr, i_cg, i_cb);
        w_blue  = i_mask[CodeBlue]  && (i_clear > 16'd250) && dom(i_refs[CodeBlue], 2, i_cr, i_cg, i_cb);
        w_yr = ref_ch(i_refs[CodeYellow], 0);
        w_yg = ref_ch(i_refs[CodeYellow], 1);
        w_yb = ref_ch(i_refs[CodeYellow], 2);
        w_sum  = 17'(i_cr) + 17'(i_cg);
        w_ysum = 17'(w_yr) + 17'(w_yg);
        w_yel = i_mask[CodeYellow] && (i_clear > 16'd250) && (i_clear < 16'd12000)
                && (24'(i_cr) * 24'd100 >= 24'(w_yr) * 24'd88)
                && (24'(i_cg) * 24'd100 >= 24'(w_yg) * 24'd88)
                && (21'(absd(i_cr, i_cg)) * 21'd10 <= 21'(absd(w_yr, w_yg)) * 21'd18)
                && (21'(i_cb) * 21'd10 <= 21'(w_yb) * 21'd15)
                && (25'(w_sum) * 25'd100 >= 25'(w_ysum) * 25'd88)
                && ({i_cb, 1'b0} <= w_sum);
    end

    // Stage A: rule flags and squared differences
    logic [31:0] r_sq [NumRef][3];
    t_rule_flags r_fa, r_fb;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fa <= '{kill: i_kill, dark: i_clear < 16'd180, bright: i_clear > 16'd450,
                      white: w_white, red: w_red, yellow: w_yel, green: w_green, blue: w_blue};
            for (int i = 0; i < NumRef; i++)
                for (int k = 0; k < 3; k++)
                    r_sq[i][k] <= absd(ref_ch(i_refs[i], k), w_c[k])
                                  * absd(ref_ch(i_refs[i], k), w_c[k]);
        end
    end

    // Stage B: sum and weight
    logic [DistW-1:0] r_d [NumRef];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fb <= r_fa;
            for (int i = 0; i < NumRef; i++)
                r_d[i] <= DistW'(34'(r_sq[i][0]) + 34'(r_sq[i][1]) + 34'(r_sq[i][2]))
                          * ((i == CodeYellow) ? 7'd55 : 7'd100);
        end
    end

    assign o_flags = r_fb;
    assign o_dist  = r_d;
endmodule

// ===== rtl/rgbc_color_classifier.sv =====
// Channel  | Signals                                      | Dir
// input    | i_valid/o_ready, i_clear..i_blue_count        | in
// result   | o_valid/i_ready, o_color_code                 | out
// config   | i_cfg_we, i_cfg_index, i_cfg_data             | in
// One item enters per cycle unless the result side stalls; the stages are the entry
// register, 30 divider steps, two rule/distance stages and the output register.
// Synchronous active-low reset clears valid bits and configuration registers.
// A stall on the result side freezes the whole pipeline; o_ready is low
// only while the output holds an item and i_ready is low.
module rgbc_color_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rgbc_pkg::CntW-1:0]     i_clear_count,
    input  logic [rgbc_pkg::CntW-1:0]     i_red_count,
    input  logic [rgbc_pkg::CntW-1:0]     i_green_count,
    input  logic [rgbc_pkg::CntW-1:0]     i_blue_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rgbc_pkg::CodeW-1:0]    o_color_code,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [rgbc_pkg::RefW-1:0]     i_cfg_data
);
    import rgbc_pkg::*;

    localparam int Lat = QuotW + 4;

    // Configuration registers
    logic              r_enable;
    logic [NumRef-1:0] r_mask;
    logic [RefW-1:0]   r_refs [NumRef];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_mask   <= '0;
            for (int i = 0; i < NumRef; i++) r_refs[i] <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                RegEnable: r_enable <= i_cfg_data[0];
                RegMask:   r_mask   <= i_cfg_data[NumRef-1:0];
                default:   r_refs[i_cfg_index - RegRed] <= i_cfg_data;
            endcase
        end
    end

    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // Valid bits travel alongside the data
    logic [Lat-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[Lat-2:0], i_valid};
    end

    // Carry clear count and kill flag alongside the dividers
    logic [CntW-1:0] r_clr [QuotW+1];
    logic            r_kil [QuotW+1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_clr[0] <= i_clear_count;
            r_kil[0] <= !r_enable || (i_clear_count < 16'd30);
            for (int s = 0; s < QuotW; s++) begin
                r_clr[s+1] <= r_clr[s];
                r_kil[s+1] <= r_kil[s];
            end
        end
    end

    logic [RatioW-1:0] w_cr, w_cg, w_cb;
    // Zero clear would be killed anyway; avoid dividing by zero
    logic [CntW-1:0] w_den;
    assign w_den = (i_clear_count == '0) ? 16'd1 : i_clear_count;
    rgbc_divider u_div_r (.i_clk, .i_en(w_en), .i_num(i_red_count),   .i_den(w_den), .o_quot(w_cr));
    rgbc_divider u_div_g (.i_clk, .i_en(w_en), .i_num(i_green_count), .i_den(w_den), .o_quot(w_cg));
    rgbc_divider u_div_b (.i_clk, .i_en(w_en), .i_num(i_blue_count),  .i_den(w_den), .o_quot(w_cb));

    t_rule_flags w_fl;
    logic [DistW-1:0] w_dist [NumRef];
    rgbc_rules u_rules (
        .i_clk, .i_en(w_en), .i_kill(r_kil[QuotW]), .i_clear(r_clr[QuotW]),
        .i_cr(w_cr), .i_cg(w_cg), .i_cb(w_cb), .i_mask(r_mask), .i_refs(r_refs),
        .o_flags(w_fl), .o_dist(w_dist)
    );

    // Priority decision and nearest reference
    t_code w_code, w_best;
    logic [DistW-1:0] w_bd;
    always_comb begin
        w_best = CodeUnknown;
        w_bd   = '0;
        for (int i = 0; i < NumRef; i++)
            if (r_mask[i] && (w_best == CodeUnknown || w_dist[i] < w_bd)) begin
                w_best = t_code'(i);
                w_bd   = w_dist[i];
            end
        if (w_fl.kill)                          w_code = CodeUnknown;
        else if (r_mask[CodeBlack] && w_fl.dark) w_code = CodeBlack;
        else if (w_fl.white)                    w_code = CodeWhite;
        else if (w_fl.red)                      w_code = CodeRed;
        else if (w_fl.yellow)                   w_code = CodeYellow;
        else if (w_fl.green)                    w_code = CodeGreen;
        else if (w_fl.blue)                     w_code = CodeBlue;
        else if (w_best == CodeUnknown || w_bd > DistLimit) w_code = CodeUnknown;
        else if (w_best == CodeBlack && w_fl.bright)        w_code = CodeUnknown;
        else                                    w_code = w_best;
    end

    logic [CodeW-1:0] r_code;
    always_ff @(posedge i_clk) begin
        if (w_en) r_code <= w_code;
    end
    assign o_color_code = r_code;
    assign o_valid      = r_vld[Lat-1];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_color_code))
        else $error("result changed under stall");
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_color_code <= CodeUnknown)
        else $error("code out of range");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("stall without pending result");
endmodule
